@@ rtl/oef_pkg.sv @@
`timescale 1ns / 1ps
// oef_pkg: shared types and constants of the one-euro filter core
// no dependencies; used by oef_div and one_euro_filter_core

package oef_pkg;

  // default width of the value path (capped at 32 inside the core)
  localparam int VALUE_WIDTH_DEF = 32;

  // field widths
  localparam int TIME_W  = 63;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W    = 30;
  localparam int RATE_W  = 48;
  localparam int ALPHA_W = 16;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // shared restoring divider widths
  localparam int DIV_REM_W = 63;
  localparam int DIV_NUM_W = 53;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] RATE_DIV_STEPS  = 6'd53;
  localparam logic [DIV_CNT_W-1:0] ALPHA_DIV_STEPS = 6'd16;

  // arithmetic constants
  localparam logic [31:0]        US_PER_S  = 32'd1000000;
  localparam logic [33:0]        TAU_K     = 34'd10430378350;
  localparam logic [DT_W-1:0]    MIN_DT_US = 30'd100;
  localparam logic [DT_W-1:0]    MAX_DT_US = 30'h3FFF_FFFF;
  localparam logic [RATE_W-1:0]  RATE_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0]  RATE_MIN  = 48'h8000_0000_0000;
  localparam logic [15:0]        HALF_LSB  = 16'h8000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CUTOFF      = 3'd0,
    CFG_BETA            = 3'd1,
    CFG_D_CUTOFF        = 3'd2,
    CFG_USE_START_VALUE = 3'd3,
    CFG_START_VALUE     = 3'd4
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_MRATE,
    S_DRATE_GO,
    S_DRATE_WAIT,
    S_RDIFF,
    S_DA1_GO,
    S_DA1_WAIT,
    S_LP1L,
    S_LP1H,
    S_RATE,
    S_RMAG,
    S_MB1,
    S_MB2,
    S_CUT,
    S_MDT2,
    S_DA2_GO,
    S_DA2_WAIT,
    S_LP2,
    S_VAL,
    S_FIN
  } oef_state_t;

  // divider command and status
  typedef struct packed {
    logic                 start;
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_REM_W-1:0] den;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/oef_div.sv @@
`timescale 1ns / 1ps
// oef_div: bit-serial restoring divider, one quotient bit per cycle
// depends on oef_pkg (div_req_t, div_rsp_t, widths)

module oef_div (
  input  logic              clk,
  input  logic              rst,
  input  oef_pkg::div_req_t req,
  output oef_pkg::div_rsp_t rsp
);

  logic [oef_pkg::DIV_REM_W-1:0] rem;
  logic [oef_pkg::DIV_REM_W-1:0] den;
  logic [oef_pkg::DIV_NUM_W-1:0] qn;
  logic [oef_pkg::DIV_CNT_W-1:0] cnt;

  logic [oef_pkg::DIV_REM_W:0] rem_sh;
  logic [oef_pkg::DIV_REM_W:0] den_ext;
  logic [oef_pkg::DIV_REM_W:0] sub;
  logic                        ge;

  // shift next dividend bit into the partial remainder
  assign rem_sh  = {rem, qn[oef_pkg::DIV_NUM_W-1]};
  assign den_ext = {1'b0, den};
  assign ge      = rem_sh >= den_ext;
  assign sub     = rem_sh - den_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= req.steps;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem;
      den <= req.den;
      qn  <= req.num;
    end else if (cnt != '0) begin
      rem <= ge ? sub[oef_pkg::DIV_REM_W-1:0] : rem_sh[oef_pkg::DIV_REM_W-1:0];
      qn  <= {qn[oef_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.busy = cnt != '0;
  assign rsp.quo  = qn;

endmodule

@@ rtl/one_euro_filter_core.sv @@
`timescale 1ns / 1ps
// one_euro_filter_core: top level of the adaptive one-euro low-pass filter
// depends on oef_pkg and oef_div

// Adaptive one-euro filter for timestamped samples (value in signed Q23.8, time in us).
// Each input transaction yields exactly one output transaction. A sample that reinitializes
// the filter (first sample, restart, or a time not later than the previous one) goes from
// acceptance through S_CHECK and S_FIN to the result register. A filtered sample is paced by
// the single bit-serial divider, which runs 53 steps for the rate (value change * 1e6 / dt)
// and 16 steps for each of the two alpha terms, while the other states sequence around one
// shared 33x32 multiplier. s_tready is high only while the sequencer is idle; the result sits
// in an output register, so the next sample can be taken while that result still waits for
// m_tready. Configuration writes are always accepted (cfg_ready is tied high) and must only
// happen while the core is idle.
// VALUE_WIDTH sets the saturation range of samples, start_value and results (capped at 32).

module one_euro_filter_core #(
  parameter int VALUE_WIDTH = oef_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // [62:0] time_us, [94:63] sample, [95] zero
  input  logic [0:0]  s_tuser,   // [0] restart
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] smoothed
  output logic [0:0]  m_tuser,   // [0] was_init
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [oef_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [oef_pkg::CFG_W-1:0]     cfg_data
);

  // effective width of the value path and its saturation bounds
  localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic signed [34:0] VAL_HI = (35'sd1 <<< (VW - 1)) - 35'sd1;
  localparam logic signed [34:0] VAL_LO = -VAL_HI - 35'sd1;

  function automatic logic signed [31:0] sat_val(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > VAL_HI) begin
      r = 32'(VAL_HI);
    end else if (v < VAL_LO) begin
      r = 32'(VAL_LO);
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // configuration registers
  logic [31:0]        min_cutoff;
  logic [31:0]        beta;
  logic [31:0]        d_cutoff;
  logic               use_start_value;
  logic signed [31:0] start_value;

  // filter state
  logic                                  started;
  logic [oef_pkg::TIME_W-1:0]            last_time;
  logic signed [31:0]                    last_smoothed;
  logic signed [oef_pkg::RATE_W-1:0]     last_rate;

  // sequencer
  oef_pkg::oef_state_t state, state_next;

  // latched input transaction
  logic [oef_pkg::TIME_W-1:0] t_in;
  logic signed [31:0]         x_in;
  logic                       restart_in;

  // working registers
  logic [oef_pkg::DT_W-1:0]          dt;
  logic                              dsign;     // sign of sample - last_smoothed
  logic [32:0]                       dmag;      // magnitude of sample - last_smoothed
  logic signed [oef_pkg::RATE_W-1:0] raw;       // unfiltered rate
  logic                              rsign;     // sign of raw - last_rate
  logic [oef_pkg::RATE_W:0]          rmag2;     // magnitude of raw - last_rate
  logic [oef_pkg::ALPHA_W-1:0]       alpha;
  logic [16:0]                       lo_round;  // rounded low partial product
  logic [oef_pkg::RATE_W-1:0]        rmag;      // |filtered rate|
  logic [55:0]                       plo;       // beta * low bits of |rate|
  logic [31:0]                       cut;       // adapted cutoff
  logic signed [31:0]                res;
  logic                              res_init;

  // shared multiplier
  logic [oef_pkg::MUL_A_W-1:0] mul_a;
  logic [oef_pkg::MUL_B_W-1:0] mul_b;
  logic [oef_pkg::MUL_P_W-1:0] p;

  // shared divider
  oef_pkg::div_req_t div_req;
  oef_pkg::div_rsp_t div_rsp;

  oef_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // input unpacking
  logic signed [31:0] sample_in;
  assign sample_in = s_tdata[94:63];

  // decision logic used in S_CHECK
  logic started_eff;
  logic reinit;
  assign started_eff = started & ~restart_in;
  assign reinit      = ~started_eff | (t_in <= last_time);

  // clamped time step
  logic [oef_pkg::TIME_W-1:0] dt_full;
  logic [oef_pkg::DT_W-1:0]   dt_clamp;
  assign dt_full = t_in - last_time;
  always_comb begin
    if (dt_full < oef_pkg::TIME_W'(oef_pkg::MIN_DT_US)) begin
      dt_clamp = oef_pkg::MIN_DT_US;
    end else if (dt_full > oef_pkg::TIME_W'(oef_pkg::MAX_DT_US)) begin
      dt_clamp = oef_pkg::MAX_DT_US;
    end else begin
      dt_clamp = dt_full[oef_pkg::DT_W-1:0];
    end
  end

  // sample minus previous output
  logic signed [32:0] vdiff;
  assign vdiff = 33'(x_in) - 33'(last_smoothed);

  // a zero cutoff counts as one lsb
  logic [31:0] dcut_nz;
  logic [31:0] cut_nz;
  assign dcut_nz = (d_cutoff == '0) ? 32'd1 : d_cutoff;
  assign cut_nz  = (cut == '0) ? 32'd1 : cut;

  // rate from the divider quotient, saturated to 48 bits signed
  logic                              q_big;
  logic signed [oef_pkg::RATE_W-1:0] raw_next;
  assign q_big = |div_rsp.quo[oef_pkg::DIV_NUM_W-1:oef_pkg::RATE_W-1];
  always_comb begin
    if (dsign) begin
      raw_next = q_big ? oef_pkg::RATE_MIN : -div_rsp.quo[oef_pkg::RATE_W-1:0];
    end else begin
      raw_next = q_big ? oef_pkg::RATE_MAX : div_rsp.quo[oef_pkg::RATE_W-1:0];
    end
  end

  // raw rate minus previous filtered rate
  logic signed [oef_pkg::RATE_W:0] rdiff;
  assign rdiff = (oef_pkg::RATE_W + 1)'(raw) - (oef_pkg::RATE_W + 1)'(last_rate);

  // rate low-pass step and saturation
  logic [49:0]        rstep;
  logic signed [50:0] rate_full;
  logic signed [oef_pkg::RATE_W-1:0] rate_sat;
  assign rstep     = 50'(p[48:0]) + 50'(lo_round);
  assign rate_full = rsign ? 51'(last_rate) - 51'(rstep) : 51'(last_rate) + 51'(rstep);
  always_comb begin
    if (rate_full > 51'(signed'(oef_pkg::RATE_MAX))) begin
      rate_sat = oef_pkg::RATE_MAX;
    end else if (rate_full < 51'(signed'(oef_pkg::RATE_MIN))) begin
      rate_sat = oef_pkg::RATE_MIN;
    end else begin
      rate_sat = rate_full[oef_pkg::RATE_W-1:0];
    end
  end

  // adapted cutoff: min_cutoff + beta*|rate|/256, saturated to 32 bits
  logic [48:0] cut_sum;
  logic [31:0] cut_next;
  assign cut_sum = 49'({p[15:0], 16'h0000}) + 49'(plo[55:8]) + 49'(min_cutoff);
  assign cut_next = ((|p[55:16]) || (|cut_sum[48:32])) ? 32'hFFFF_FFFF : cut_sum[31:0];

  // value low-pass step
  logic [48:0]        vround;
  logic [32:0]        vstep;
  logic signed [34:0] y_full;
  assign vround = p[48:0] + 49'(oef_pkg::HALF_LSB);
  assign vstep  = vround[48:16];
  assign y_full = dsign ? 35'(last_smoothed) - 35'(vstep) : 35'(last_smoothed) + 35'(vstep);

  // output register is free for a new result
  logic out_free;
  assign out_free = ~m_tvalid | m_tready;

  assign s_tready  = (state == oef_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cutoff      <= 32'd65536;
      beta            <= '0;
      d_cutoff        <= 32'd65536;
      use_start_value <= 1'b0;
      start_value     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        oef_pkg::CFG_MIN_CUTOFF:      min_cutoff      <= cfg_data;
        oef_pkg::CFG_BETA:            beta            <= cfg_data;
        oef_pkg::CFG_D_CUTOFF:        d_cutoff        <= cfg_data;
        oef_pkg::CFG_USE_START_VALUE: use_start_value <= cfg_data[0];
        oef_pkg::CFG_START_VALUE:     start_value     <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oef_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, multiplier operands and divider commands
  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.rem   = '0;
    div_req.den   = '0;
    div_req.num   = '0;
    div_req.steps = '0;
    unique case (state)
      oef_pkg::S_IDLE: begin
        if (s_tvalid) state_next = oef_pkg::S_CHECK;
      end
      oef_pkg::S_CHECK: begin
        state_next = reinit ? oef_pkg::S_FIN : oef_pkg::S_MRATE;
      end
      oef_pkg::S_MRATE: begin
        // value change scaled to per second
        mul_a      = dmag;
        mul_b      = oef_pkg::US_PER_S;
        state_next = oef_pkg::S_DRATE_GO;
      end
      oef_pkg::S_DRATE_GO: begin
        div_req.start = 1'b1;
        div_req.num   = p[oef_pkg::DIV_NUM_W-1:0];
        div_req.den   = oef_pkg::DIV_REM_W'(dt);
        div_req.steps = oef_pkg::RATE_DIV_STEPS;
        state_next    = oef_pkg::S_DRATE_WAIT;
      end
      oef_pkg::S_DRATE_WAIT: begin
        if (!div_rsp.busy) state_next = oef_pkg::S_RDIFF;
      end
      oef_pkg::S_RDIFF: begin
        mul_a      = oef_pkg::MUL_A_W'(dt);
        mul_b      = dcut_nz;
        state_next = oef_pkg::S_DA1_GO;
      end
      oef_pkg::S_DA1_GO: begin
        // alpha = n / (n + K) as a 16-bit fraction
        div_req.start = 1'b1;
        div_req.rem   = p[oef_pkg::DIV_REM_W-1:0];
        div_req.den   = p[oef_pkg::DIV_REM_W-1:0] + oef_pkg::DIV_REM_W'(oef_pkg::TAU_K);
        div_req.steps = oef_pkg::ALPHA_DIV_STEPS;
        state_next    = oef_pkg::S_DA1_WAIT;
      end
      oef_pkg::S_DA1_WAIT: begin
        if (!div_rsp.busy) state_next = oef_pkg::S_LP1L;
      end
      oef_pkg::S_LP1L: begin
        mul_a      = oef_pkg::MUL_A_W'(rmag2[15:0]);
        mul_b      = oef_pkg::MUL_B_W'(alpha);
        state_next = oef_pkg::S_LP1H;
      end
      oef_pkg::S_LP1H: begin
        mul_a      = rmag2[oef_pkg::RATE_W:16];
        mul_b      = oef_pkg::MUL_B_W'(alpha);
        state_next = oef_pkg::S_RATE;
      end
      oef_pkg::S_RATE: begin
        state_next = oef_pkg::S_RMAG;
      end
      oef_pkg::S_RMAG: begin
        state_next = oef_pkg::S_MB1;
      end
      oef_pkg::S_MB1: begin
        mul_a      = oef_pkg::MUL_A_W'(rmag[23:0]);
        mul_b      = beta;
        state_next = oef_pkg::S_MB2;
      end
      oef_pkg::S_MB2: begin
        mul_a      = oef_pkg::MUL_A_W'(rmag[oef_pkg::RATE_W-1:24]);
        mul_b      = beta;
        state_next = oef_pkg::S_CUT;
      end
      oef_pkg::S_CUT: begin
        state_next = oef_pkg::S_MDT2;
      end
      oef_pkg::S_MDT2: begin
        mul_a      = oef_pkg::MUL_A_W'(dt);
        mul_b      = cut_nz;
        state_next = oef_pkg::S_DA2_GO;
      end
      oef_pkg::S_DA2_GO: begin
        div_req.start = 1'b1;
        div_req.rem   = p[oef_pkg::DIV_REM_W-1:0];
        div_req.den   = p[oef_pkg::DIV_REM_W-1:0] + oef_pkg::DIV_REM_W'(oef_pkg::TAU_K);
        div_req.steps = oef_pkg::ALPHA_DIV_STEPS;
        state_next    = oef_pkg::S_DA2_WAIT;
      end
      oef_pkg::S_DA2_WAIT: begin
        if (!div_rsp.busy) state_next = oef_pkg::S_LP2;
      end
      oef_pkg::S_LP2: begin
        mul_a      = dmag;
        mul_b      = oef_pkg::MUL_B_W'(alpha);
        state_next = oef_pkg::S_VAL;
      end
      oef_pkg::S_VAL: begin
        state_next = oef_pkg::S_FIN;
      end
      oef_pkg::S_FIN: begin
        // hold until the output register can take the result
        if (out_free) state_next = oef_pkg::S_IDLE;
      end
      default: begin
        state_next = oef_pkg::S_IDLE;
      end
    endcase
  end

  // product register after the shared multiplier
  always_ff @(posedge clk) begin
    p <= oef_pkg::MUL_P_W'(mul_a) * oef_pkg::MUL_P_W'(mul_b);
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      oef_pkg::S_IDLE: begin
        if (s_tvalid) begin
          t_in       <= s_tdata[oef_pkg::TIME_W-1:0];
          x_in       <= sat_val(35'(sample_in));
          restart_in <= s_tuser[0];
        end
      end
      oef_pkg::S_CHECK: begin
        dt    <= dt_clamp;
        dsign <= vdiff[32];
        dmag  <= vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
        // baseline: start_value only on a first start or a restart with the option on
        res      <= (!started_eff && use_start_value) ? sat_val(35'(start_value)) : x_in;
        res_init <= 1'b1;
      end
      oef_pkg::S_DRATE_WAIT: begin
        if (!div_rsp.busy) raw <= raw_next;
      end
      oef_pkg::S_RDIFF: begin
        rsign <= rdiff[oef_pkg::RATE_W];
        rmag2 <= rdiff[oef_pkg::RATE_W] ? (oef_pkg::RATE_W + 1)'(-rdiff)
                                          : (oef_pkg::RATE_W + 1)'(rdiff);
      end
      oef_pkg::S_DA1_WAIT, oef_pkg::S_DA2_WAIT: begin
        if (!div_rsp.busy) alpha <= div_rsp.quo[oef_pkg::ALPHA_W-1:0];
      end
      oef_pkg::S_LP1H: begin
        // low partial product, rounded to nearest
        lo_round <= 17'((p[32:0] + 33'(oef_pkg::HALF_LSB)) >> 16);
      end
      oef_pkg::S_RMAG: begin
        rmag <= last_rate[oef_pkg::RATE_W-1] ? oef_pkg::RATE_W'(-last_rate)
                                             : oef_pkg::RATE_W'(last_rate);
      end
      oef_pkg::S_MB2: begin
        plo <= p[55:0];
      end
      oef_pkg::S_CUT: begin
        cut <= cut_next;
      end
      oef_pkg::S_VAL: begin
        res      <= sat_val(y_full);
        res_init <= 1'b0;
      end
      default: ;
    endcase
  end

  // filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      last_time     <= '0;
      last_smoothed <= '0;
      last_rate     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == oef_pkg::S_CHECK && reinit) begin
        last_rate <= '0;
      end
      if (state == oef_pkg::S_RATE) begin
        last_rate <= rate_sat;
      end
      if (state == oef_pkg::S_FIN && out_free) begin
        started       <= 1'b1;
        last_time     <= t_in;
        last_smoothed <= res;
        m_tvalid      <= 1'b1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state == oef_pkg::S_FIN && out_free) begin
      m_tdata <= res;
      m_tuser <= res_init;
    end
  end

endmodule
